FILE: src/p3prc_pkg.sv
`timescale 1ns / 1ps
package p3prc_pkg;

    localparam int VAL_BITS = 19;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int SHIFT_BITS = 4;
    localparam int CFG_IDX_BITS = 1;
    localparam int CFG_DATA_BITS = 4;
    localparam int WARM_BITS = 2;

    localparam logic signed [VAL_BITS-1:0] VAL_MAX = VAL_BITS'((1 << (VAL_BITS - 1)) - 1);
    localparam logic signed [VAL_BITS-1:0] VAL_MIN = VAL_BITS'(-(1 << (VAL_BITS - 1)));

    localparam logic [WARM_BITS-1:0] WARM_NONE = 2'd0;
    localparam logic [WARM_BITS-1:0] WARM_ONE  = 2'd1;
    localparam logic [WARM_BITS-1:0] WARM_TWO  = 2'd2;
    localparam logic [WARM_BITS-1:0] WARM_FULL = 2'd3;

    typedef enum logic {
        DIR_ENCODE = 1'b0,
        DIR_DECODE = 1'b1
    } t_dir;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_DIRECTION    = 1'b0,
        CFG_BITS_TO_DROP = 1'b1
    } t_cfg_idx;

endpackage

FILE: src/p3prc_in_if.sv
`timescale 1ns / 1ps
interface p3prc_in_if;
    logic valid;
    logic ready;
    logic signed [p3prc_pkg::VAL_BITS-1:0] value_in;

    modport source (output valid, output value_in, input ready);
    modport sink (input valid, input value_in, output ready);
endinterface

FILE: src/p3prc_out_if.sv
`timescale 1ns / 1ps
interface p3prc_out_if;
    logic valid;
    logic ready;
    logic signed [p3prc_pkg::VAL_BITS-1:0] value_out;

    modport source (output valid, output value_out, input ready);
    modport sink (input valid, input value_out, output ready);
endinterface

FILE: src/p3prc_history.sv
`timescale 1ns / 1ps
module p3prc_history #(
    parameter int SAMPLE_BITS = p3prc_pkg::SAMPLE_BITS_DEF,
    parameter int PRED_BITS = SAMPLE_BITS + 4
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    output logic signed [PRED_BITS-1:0]   o_pred
);

    logic signed [SAMPLE_BITS-1:0] r_hist_one;
    logic signed [SAMPLE_BITS-1:0] r_hist_two;
    logic signed [SAMPLE_BITS-1:0] r_hist_three;
    logic [p3prc_pkg::WARM_BITS-1:0] r_warm;
    logic [p3prc_pkg::WARM_BITS-1:0] n_warm;

    logic signed [PRED_BITS-1:0] h1;
    logic signed [PRED_BITS-1:0] h2;
    logic signed [PRED_BITS-1:0] h3;

    assign h1 = PRED_BITS'(r_hist_one);
    assign h2 = PRED_BITS'(r_hist_two);
    assign h3 = PRED_BITS'(r_hist_three);

    always_comb begin
        case (r_warm)
            p3prc_pkg::WARM_NONE: o_pred = '0;
            p3prc_pkg::WARM_ONE:  o_pred = h1;
            p3prc_pkg::WARM_TWO:  o_pred = (h1 <<< 1) - h2;
            default:              o_pred = (h1 <<< 1) + h1 - (h2 <<< 1) - h2 + h3;
        endcase
    end

    assign n_warm = (r_warm == p3prc_pkg::WARM_FULL) ? r_warm : r_warm + 2'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist_one   <= '0;
            r_hist_two   <= '0;
            r_hist_three <= '0;
            r_warm       <= p3prc_pkg::WARM_NONE;
        end else if (i_push) begin
            r_hist_one   <= i_sample;
            r_hist_two   <= r_hist_one;
            r_hist_three <= r_hist_two;
            r_warm       <= n_warm;
        end
    end

endmodule

FILE: src/p3prc_datapath.sv
`timescale 1ns / 1ps
module p3prc_datapath #(
    parameter int SAMPLE_BITS = p3prc_pkg::SAMPLE_BITS_DEF,
    parameter int PRED_BITS = SAMPLE_BITS + 4
) (
    input  p3prc_pkg::t_dir                              i_dir,
    input  logic [p3prc_pkg::SHIFT_BITS-1:0]             i_shift,
    input  logic signed [p3prc_pkg::VAL_BITS-1:0]        i_value,
    input  logic signed [PRED_BITS-1:0]                  i_pred,
    output logic signed [SAMPLE_BITS-1:0]                o_sample,
    output logic signed [p3prc_pkg::VAL_BITS-1:0]        o_result
);

    localparam int VB = p3prc_pkg::VAL_BITS;
    localparam int SB = p3prc_pkg::SHIFT_BITS;
    localparam int W = ((SAMPLE_BITS > VB) ? SAMPLE_BITS : VB) + 4;
    localparam int SW = SAMPLE_BITS + (1 << SB);
    localparam int BW = 1 << SB;

    localparam logic signed [W-1:0] SMP_MAX = W'((1 << (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [W-1:0] SMP_MIN = W'(-(1 << (SAMPLE_BITS - 1)));
    localparam logic signed [W-1:0] VMAX_W = W'(p3prc_pkg::VAL_MAX);
    localparam logic signed [W-1:0] VMIN_W = W'(p3prc_pkg::VAL_MIN);
    localparam logic signed [SW-1:0] VMAX_S = SW'(p3prc_pkg::VAL_MAX);
    localparam logic signed [SW-1:0] VMIN_S = SW'(p3prc_pkg::VAL_MIN);

    logic signed [W-1:0]           v_w;
    logic signed [W-1:0]           v_cl;
    logic [BW-1:0]                 bias;
    logic signed [SW-1:0]          div_sum;
    logic signed [SW-1:0]          div_q;
    logic signed [SAMPLE_BITS-1:0] q_enc;
    logic signed [W-1:0]           res_w;
    logic signed [VB-1:0]          res_enc;
    logic signed [W-1:0]           sum_dec;
    logic signed [SAMPLE_BITS-1:0] q_dec;
    logic signed [SW-1:0]          up_w;
    logic signed [VB-1:0]          res_dec;

    assign v_w = W'(i_value);

    // encode: clamp then divide by 2^k toward zero
    always_comb begin
        if (v_w > SMP_MAX) begin
            v_cl = SMP_MAX;
        end else if (v_w < SMP_MIN) begin
            v_cl = SMP_MIN;
        end else begin
            v_cl = v_w;
        end
    end

    assign bias    = (BW'(1) << i_shift) - BW'(1);
    assign div_sum = SW'($signed(v_cl[SAMPLE_BITS-1:0]))
                   + (v_cl[W-1] ? $signed({{(SW-BW){1'b0}}, bias}) : SW'(0));
    assign div_q   = div_sum >>> i_shift;
    assign q_enc   = div_q[SAMPLE_BITS-1:0];
    assign res_w   = W'(q_enc) - W'(i_pred);

    always_comb begin
        if (res_w > VMAX_W) begin
            res_enc = p3prc_pkg::VAL_MAX;
        end else if (res_w < VMIN_W) begin
            res_enc = p3prc_pkg::VAL_MIN;
        end else begin
            res_enc = res_w[VB-1:0];
        end
    end

    // decode: rebuild, saturate, scale back up
    assign sum_dec = W'(i_pred) + v_w;

    always_comb begin
        if (sum_dec > SMP_MAX) begin
            q_dec = SMP_MAX[SAMPLE_BITS-1:0];
        end else if (sum_dec < SMP_MIN) begin
            q_dec = SMP_MIN[SAMPLE_BITS-1:0];
        end else begin
            q_dec = sum_dec[SAMPLE_BITS-1:0];
        end
    end

    assign up_w = SW'(q_dec) <<< i_shift;

    always_comb begin
        if (up_w > VMAX_S) begin
            res_dec = p3prc_pkg::VAL_MAX;
        end else if (up_w < VMIN_S) begin
            res_dec = p3prc_pkg::VAL_MIN;
        end else begin
            res_dec = up_w[VB-1:0];
        end
    end

    always_comb begin
        case (i_dir)
            p3prc_pkg::DIR_ENCODE: begin
                o_sample = q_enc;
                o_result = res_enc;
            end
            p3prc_pkg::DIR_DECODE: begin
                o_sample = q_dec;
                o_result = res_dec;
            end
            default: begin
                o_sample = q_enc;
                o_result = res_enc;
            end
        endcase
    end

endmodule

FILE: src/poly3_predictive_residual_codec.sv
`timescale 1ns / 1ps
// Third-order fixed polynomial predictor for audio samples, one beat in and one beat out per
// item. With direction at encode a 19-bit input is clamped to SAMPLE_BITS, divided by
// 2^bits_to_drop toward zero and returned as a saturated residual against the prediction;
// with direction at decode the input is taken as a residual and the saturated rebuilt sample
// comes back shifted up by bits_to_drop. The predictor order climbs 0, 1, 2, 3 over the first
// samples after reset, and the history is one stream for every beat whatever its channel.
// Items go through an input register and a result register with all the arithmetic
// combinational between them, so one item is taken every cycle while the receiver takes
// results; a stalled result holds, and the input side stalls once the input register is
// full as well. Write the registers only while the block is empty; a change applies from
// the next item and leaves the history as it is.
module poly3_predictive_residual_codec #(
    parameter int SAMPLE_BITS = p3prc_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    p3prc_in_if.sink                              i_in,
    p3prc_out_if.source                           o_out,
    input  logic                                  i_cfg_we,
    input  logic [p3prc_pkg::CFG_IDX_BITS-1:0]    i_cfg_idx,
    input  logic [p3prc_pkg::CFG_DATA_BITS-1:0]   i_cfg_data
);

    localparam int VB = p3prc_pkg::VAL_BITS;
    localparam int W = ((SAMPLE_BITS > VB) ? SAMPLE_BITS : VB) + 4;

    p3prc_pkg::t_dir                     r_dir;
    logic [p3prc_pkg::SHIFT_BITS-1:0]    r_shift;

    logic                                r_in_valid;
    logic signed [VB-1:0]                r_in_value;
    logic                                r_out_valid;
    logic signed [VB-1:0]                r_out_value;

    logic                                advance;
    logic                                push;
    logic signed [W-1:0]                 pred;
    logic signed [SAMPLE_BITS-1:0]       sample;
    logic signed [VB-1:0]                result;

    assign advance     = !r_out_valid || o_out.ready;
    assign push        = advance && r_in_valid;
    assign i_in.ready  = !r_in_valid || advance;
    assign o_out.valid = r_out_valid;
    assign o_out.value_out = r_out_value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir   <= p3prc_pkg::DIR_ENCODE;
            r_shift <= '0;
        end else if (i_cfg_we) begin
            case (p3prc_pkg::t_cfg_idx'(i_cfg_idx))
                p3prc_pkg::CFG_DIRECTION:    r_dir   <= p3prc_pkg::t_dir'(i_cfg_data[0]);
                p3prc_pkg::CFG_BITS_TO_DROP: r_shift <= i_cfg_data[p3prc_pkg::SHIFT_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_value <= i_in.value_in;
        end
        if (push) begin
            r_out_value <= result;
        end
    end

    p3prc_history #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .PRED_BITS   (W)
    ) u_history (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_sample (sample),
        .o_pred   (pred)
    );

    p3prc_datapath #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .PRED_BITS   (W)
    ) u_datapath (
        .i_dir    (r_dir),
        .i_shift  (r_shift),
        .i_value  (r_in_value),
        .i_pred   (pred),
        .o_sample (sample),
        .o_result (result)
    );

endmodule

FILE: src/p3prc_checker.sv
`timescale 1ns / 1ps
module p3prc_checker (
    input logic                                  i_clk,
    input logic                                  i_rst_n,
    input logic                                  i_in_valid,
    input logic                                  i_in_ready,
    input logic                                  i_out_valid,
    input logic                                  i_out_ready,
    input logic signed [p3prc_pkg::VAL_BITS-1:0] i_out_value
);

    // nothing shown straight after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result beat shown after reset");

    // a free output side never blocks the input side
    a_no_bubble: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_out_valid || i_out_ready) |-> i_in_ready)
        else $error("input stalled while output is free");

    // every accepted beat is followed by a result on show once it has passed the input register
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> ##1 i_out_valid)
        else $error("no result two cycles after an input beat");

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_value)))
        else $error("stalled result changed");

endmodule

bind poly3_predictive_residual_codec p3prc_checker u_p3prc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_value (o_out.value_out)
);

FILE: dv/poly3_predictive_residual_codec_tb.sv
`timescale 1ns / 1ps
module poly3_predictive_residual_codec_tb;

    localparam int SAMPLE_W = p3prc_pkg::SAMPLE_BITS_DEF;
    localparam int VB = p3prc_pkg::VAL_BITS;
    localparam int SH = p3prc_pkg::SHIFT_BITS;
    localparam int SETTLE_CYCLES = 4;
    localparam int QUIET_LIMIT = 1000;
    localparam int PHASES = 8;
    localparam int ITEMS_PER_PHASE = 117;

    typedef struct {
        p3prc_pkg::t_dir             dir;
        logic [SH-1:0]               drop;
        logic signed [VB-1:0]        value;
        bit                          known;
        logic signed [VB-1:0]        result;
    } t_probe;

    logic                                 i_clk = 1'b0;
    logic                                 i_rst_n;
    logic                                 i_cfg_we;
    p3prc_pkg::t_cfg_idx                  i_cfg_idx;
    logic [p3prc_pkg::CFG_DATA_BITS-1:0]  i_cfg_data;

    p3prc_in_if  in_bus ();
    p3prc_out_if out_bus ();

    poly3_predictive_residual_codec #(
        .SAMPLE_BITS(SAMPLE_W)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_bus),
        .o_out      (out_bus),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // predictor state
    logic signed [SAMPLE_W-1:0]         recent [3] = '{default: '0};
    logic [p3prc_pkg::WARM_BITS-1:0]    warm_q = p3prc_pkg::WARM_NONE;
    p3prc_pkg::t_dir                    dir_q = p3prc_pkg::DIR_ENCODE;
    logic [SH-1:0]                      drop_q = '0;

    logic signed [VB-1:0]       expected_out [$];
    int                         mismatches = 0;
    int                         quiet_cycles = 0;
    int                         idle_pct = 0;
    int                         stall_pct = 0;
    longint                     walk = 0;

    t_probe probes [16] = '{
        '{p3prc_pkg::DIR_ENCODE, 4'd0,  19'sd32767,         1'b1, 19'sd32767},
        '{p3prc_pkg::DIR_ENCODE, 4'd0,  -19'sd32768,        1'b1, -19'sd65535},
        '{p3prc_pkg::DIR_ENCODE, 4'd0,  p3prc_pkg::VAL_MAX, 1'b0, 19'sd0},
        '{p3prc_pkg::DIR_ENCODE, 4'd0,  p3prc_pkg::VAL_MIN, 1'b0, 19'sd0},
        '{p3prc_pkg::DIR_ENCODE, 4'd15, -19'sd32768,        1'b0, 19'sd0},
        '{p3prc_pkg::DIR_ENCODE, 4'd15, 19'sd32767,         1'b0, 19'sd0},
        '{p3prc_pkg::DIR_ENCODE, 4'd15, -19'sd32767,        1'b0, 19'sd0},
        '{p3prc_pkg::DIR_ENCODE, 4'd1,  -19'sd3,            1'b0, 19'sd0},
        '{p3prc_pkg::DIR_DECODE, 4'd0,  p3prc_pkg::VAL_MAX, 1'b1, 19'sd32767},
        '{p3prc_pkg::DIR_DECODE, 4'd0,  p3prc_pkg::VAL_MIN, 1'b1, -19'sd32768},
        '{p3prc_pkg::DIR_DECODE, 4'd15, p3prc_pkg::VAL_MAX, 1'b1, p3prc_pkg::VAL_MAX},
        '{p3prc_pkg::DIR_DECODE, 4'd15, p3prc_pkg::VAL_MIN, 1'b1, p3prc_pkg::VAL_MIN},
        '{p3prc_pkg::DIR_DECODE, 4'd3,  19'sd0,             1'b0, 19'sd0},
        '{p3prc_pkg::DIR_DECODE, 4'd3,  19'sd5,             1'b0, 19'sd0},
        '{p3prc_pkg::DIR_DECODE, 4'd3,  -19'sd7,            1'b0, 19'sd0},
        '{p3prc_pkg::DIR_ENCODE, 4'd0,  19'sd0,             1'b0, 19'sd0}
    };

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    function automatic longint saturate(input longint x, input int bits);
        longint hi;
        longint lo;
        hi = (longint'(1) << (bits - 1)) - 1;
        lo = -hi - 1;
        if (x > hi) return hi;
        if (x < lo) return lo;
        return x;
    endfunction

    function automatic longint prediction();
        longint h1;
        longint h2;
        longint h3;
        h1 = recent[0];
        h2 = recent[1];
        h3 = recent[2];
        case (warm_q)
            p3prc_pkg::WARM_NONE: return 0;
            p3prc_pkg::WARM_ONE:  return h1;
            p3prc_pkg::WARM_TWO:  return 2 * h1 - h2;
            default:              return 3 * h1 - 3 * h2 + h3;
        endcase
    endfunction

    function automatic logic signed [VB-1:0] step_codec(
        input logic signed [VB-1:0] v
    );
        longint guess;
        longint q;
        longint r;
        guess = prediction();
        if (dir_q == p3prc_pkg::DIR_ENCODE) begin
            q = saturate(longint'(v), SAMPLE_W) / (longint'(1) << drop_q);
            r = saturate(q - guess, VB);
        end else begin
            q = saturate(guess + longint'(v), SAMPLE_W);
            r = saturate(q * (longint'(1) << drop_q), VB);
        end
        recent[2] = recent[1];
        recent[1] = recent[0];
        recent[0] = SAMPLE_W'(q);
        if (warm_q != p3prc_pkg::WARM_FULL) warm_q = warm_q + 1'b1;
        return VB'(r);
    endfunction

    // mostly a smooth waveform, or residuals that follow one, with some noise and extremes
    function automatic logic signed [VB-1:0] draw_value();
        logic signed [VB-1:0] corners [6];
        int pick;
        int delta;
        int noise;
        corners = '{p3prc_pkg::VAL_MAX, p3prc_pkg::VAL_MIN, 19'sd32767, -19'sd32768,
                    19'sd0, -19'sd1};
        pick = $urandom_range(99);
        delta = int'($urandom_range(2000)) - 1000;
        noise = int'($urandom_range(6)) - 3;
        walk = saturate(walk + delta, SAMPLE_W);
        if (pick < 10) return VB'($urandom);
        if (pick < 16) return corners[$urandom_range(5)];
        if (dir_q == p3prc_pkg::DIR_ENCODE) return VB'(walk + noise);
        return VB'(walk / (longint'(1) << drop_q) - prediction() + noise);
    endfunction

    task automatic offer(input logic signed [VB-1:0] v);
        while ($urandom_range(99) < idle_pct) begin
            in_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_bus.valid <= 1'b1;
        in_bus.value_in <= v;
        @(posedge i_clk);
        while (!in_bus.ready) @(posedge i_clk);
    endtask

    task automatic drain();
        in_bus.valid <= 1'b0;
        while (expected_out.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_mode(input p3prc_pkg::t_dir d, input logic [SH-1:0] s);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_idx <= p3prc_pkg::CFG_DIRECTION;
        i_cfg_data <= p3prc_pkg::CFG_DATA_BITS'(d);
        @(posedge i_clk);
        i_cfg_idx <= p3prc_pkg::CFG_BITS_TO_DROP;
        i_cfg_data <= s;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        dir_q = d;
        drop_q = s;
    endtask

    initial begin
        logic signed [VB-1:0] v;
        logic signed [VB-1:0] r;
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_idx <= p3prc_pkg::CFG_DIRECTION;
        i_cfg_data <= '0;
        in_bus.valid <= 1'b0;
        in_bus.value_in <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (probes[i]) begin
            if (probes[i].dir != dir_q || probes[i].drop != drop_q)
                set_mode(probes[i].dir, probes[i].drop);
            offer(probes[i].value);
            r = step_codec(probes[i].value);
            expected_out.insert(expected_out.size(), probes[i].known ? probes[i].result : r);
        end

        for (int k = 0; k < PHASES; k++) begin
            case (k % 4)
                0: begin
                    idle_pct = 0;
                    stall_pct = 0;
                end
                1: begin
                    idle_pct = 52;
                    stall_pct = 0;
                end
                2: begin
                    idle_pct = 0;
                    stall_pct = 52;
                end
                default: begin
                    idle_pct = 29;
                    stall_pct = 29;
                end
            endcase
            case (k)
                0: set_mode(p3prc_pkg::DIR_ENCODE, 4'd0);
                1: set_mode(p3prc_pkg::DIR_DECODE, 4'd15);
                2: set_mode(p3prc_pkg::DIR_ENCODE, 4'd15);
                3: set_mode(p3prc_pkg::DIR_DECODE, 4'd0);
                default: set_mode(p3prc_pkg::t_dir'($urandom_range(1)),
                                  SH'($urandom_range(15)));
            endcase
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (k == 5 && n == ITEMS_PER_PHASE / 2) drain();
                v = draw_value();
                offer(v);
                expected_out.insert(expected_out.size(), step_codec(v));
            end
        end

        drain();
        if (mismatches == 0 && expected_out.size() == 0) begin
            $display("** poly3_predictive_residual_codec: PASSED **");
        end else begin
            $display("** poly3_predictive_residual_codec: FAILED **");
        end
        $finish;
    end

    // result beats checked in order, receiver stalls drawn per cycle
    initial begin
        logic signed [VB-1:0] want;
        out_bus.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n) begin
                if (out_bus.valid && out_bus.ready) begin
                    if (expected_out.size() == 0) begin
                        $error("value_out: expected none, actual %0d", out_bus.value_out);
                        mismatches++;
                    end else begin
                        want = expected_out.pop_front();
                        if (out_bus.value_out !== want) begin
                            $error("value_out: expected %0d, actual %0d", want,
                                   out_bus.value_out);
                            mismatches++;
                        end
                    end
                end
                quiet_cycles <= ((in_bus.valid && in_bus.ready) ||
                                 (out_bus.valid && out_bus.ready)) ? 0 : quiet_cycles + 1;
            end
            out_bus.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    initial begin
        do @(posedge i_clk); while (quiet_cycles < QUIET_LIMIT);
        $display("** poly3_predictive_residual_codec: FAILED **");
        $finish;
    end

endmodule
